>>> hw/rtl/hex_text_record_loader_defines.svh
// assertion macros for the hex text record loader
`ifndef HEX_TEXT_RECORD_LOADER_DEFINES_SVH
`define HEX_TEXT_RECORD_LOADER_DEFINES_SVH

// implication checked on every clock edge out of reset
`define HTRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htrl: implication check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define HTRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htrl: next-cycle check failed");

`endif

>>> hw/rtl/htrl_pkg.sv
`default_nettype none

package htrl_pkg;

  typedef enum logic [2:0] {
    StepNone      = 3'd0,
    StepDataAddr  = 3'd1,
    StepDataByte  = 3'd2,
    StepScrAddr   = 3'd3,
    StepScrWidth  = 3'd4,
    StepScrHeight = 3'd5,
    StepScrPoints = 3'd6,
    StepScrLines  = 3'd7
  } step_e;

  localparam logic [7:0] CharBlockData   = 8'h69;
  localparam logic [7:0] CharBlockScreen = 8'h73;
  localparam logic [7:0] CharSpace       = 8'h20;
  localparam logic [7:0] CharComma       = 8'h2c;
  localparam logic [7:0] CharCr          = 8'h0d;
  localparam logic [7:0] CharZero        = 8'h30;
  localparam logic [7:0] CharNine        = 8'h39;
  localparam logic [7:0] CharLowerA      = 8'h61;
  localparam logic [7:0] CharLowerF      = 8'h66;
  localparam logic [7:0] CharUpperA      = 8'h41;
  localparam logic [7:0] CharUpperF      = 8'h46;
  localparam logic [7:0] DigitTen        = 8'd10;

  localparam logic KindData   = 1'b0;
  localparam logic KindScreen = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  screen_number;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [15:0] points;
    logic [15:0] lines;
  } record_t;

endpackage

`default_nettype wire

>>> hw/rtl/hex_text_record_loader.sv
// Hex text record loader: parses a hex listing one ASCII character per transaction and emits
// one record per finished data byte ('i' blocks) or per finished screen descriptor ('s'
// blocks). A character is taken in every cycle in which the input is not stalled; its effect
// on the parser state and any record it completes are worked out in that cycle, and the record
// is registered in the output register or, while the output is stalled, in a second register
// behind it that holds one more record; the input stalls only while that register is full.
// Reset leaves no block open, in word mode.
`default_nettype none

`include "hex_text_record_loader_defines.svh"

module hex_text_record_loader (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  character_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             record_kind_o,
  output logic [15:0]      record_address_o,
  output logic [7:0]       data_value_o,
  output logic [7:0]       screen_number_o,
  output logic [7:0]       screen_width_o,
  output logic [7:0]       screen_height_o,
  output logic [15:0]      points_address_o,
  output logic [15:0]      lines_address_o
);

  htrl_pkg::step_e step_q, step_d;
  logic        word_mode_q, word_mode_d;
  logic        have_digits_q, have_digits_d;
  logic [7:0]  byte_acc_q, byte_acc_d;
  logic [15:0] word_acc_q, word_acc_d;
  logic [15:0] cur_addr_q, cur_addr_d;
  logic [7:0]  screen_cnt_q, screen_cnt_d;
  logic [15:0] pend_addr_q, pend_addr_d;
  logic [7:0]  pend_width_q, pend_width_d;
  logic [7:0]  pend_height_q, pend_height_d;
  logic [15:0] pend_points_q, pend_points_d;

  htrl_pkg::record_t res;
  logic              res_valid;
  htrl_pkg::record_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  htrl_pkg::record_t skid_q, skid_d;
  logic              skid_valid_q, skid_valid_d;

  logic       accept;
  logic       is_hex;
  logic       is_sep;
  logic [3:0] nib;
  logic [7:0] c;

  assign c          = character_i;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  // hex digit decode
  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (c >= htrl_pkg::CharZero && c <= htrl_pkg::CharNine) begin
      nib = 4'(c - htrl_pkg::CharZero);
    end else if (c >= htrl_pkg::CharLowerA && c <= htrl_pkg::CharLowerF) begin
      nib = 4'(c - htrl_pkg::CharLowerA + htrl_pkg::DigitTen);
    end else if (c >= htrl_pkg::CharUpperA && c <= htrl_pkg::CharUpperF) begin
      nib = 4'(c - htrl_pkg::CharUpperA + htrl_pkg::DigitTen);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_sep = (c == htrl_pkg::CharSpace) || (c == htrl_pkg::CharComma) ||
                  (c == htrl_pkg::CharCr);

  // parser next state and record
  always_comb begin
    step_d        = step_q;
    word_mode_d   = word_mode_q;
    have_digits_d = have_digits_q;
    byte_acc_d    = byte_acc_q;
    word_acc_d    = word_acc_q;
    cur_addr_d    = cur_addr_q;
    screen_cnt_d  = screen_cnt_q;
    pend_addr_d   = pend_addr_q;
    pend_width_d  = pend_width_q;
    pend_height_d = pend_height_q;
    pend_points_d = pend_points_q;
    res           = '0;
    res_valid     = 1'b0;

    if (is_hex) begin
      if (word_mode_q) begin
        word_acc_d = {word_acc_q[11:0], nib};
      end else begin
        byte_acc_d = {byte_acc_q[3:0], nib};
      end
      have_digits_d = 1'b1;
    end else if (is_sep) begin
      have_digits_d = 1'b0;
      if (!word_mode_q) begin
        if (have_digits_q) begin
          case (step_q)
            htrl_pkg::StepDataByte: begin
              res.kind    = htrl_pkg::KindData;
              res.address = cur_addr_q;
              res.data    = byte_acc_q;
              res_valid   = 1'b1;
            end
            htrl_pkg::StepScrWidth: begin
              pend_addr_d  = cur_addr_q;
              pend_width_d = byte_acc_q;
              step_d       = htrl_pkg::StepScrHeight;
            end
            htrl_pkg::StepScrHeight: begin
              pend_height_d = byte_acc_q;
              step_d        = htrl_pkg::StepScrPoints;
              word_mode_d   = 1'b1;
            end
            default: begin
            end
          endcase
        end
        byte_acc_d = '0;
        cur_addr_d = cur_addr_q + 16'd1;
      end else begin
        if (have_digits_q) begin
          case (step_q)
            htrl_pkg::StepDataAddr: begin
              cur_addr_d  = word_acc_q;
              step_d      = htrl_pkg::StepDataByte;
              word_mode_d = 1'b0;
            end
            htrl_pkg::StepScrAddr: begin
              cur_addr_d  = word_acc_q;
              step_d      = htrl_pkg::StepScrWidth;
              word_mode_d = 1'b0;
            end
            htrl_pkg::StepScrPoints: begin
              pend_points_d = word_acc_q;
              step_d        = htrl_pkg::StepScrLines;
            end
            htrl_pkg::StepScrLines: begin
              res.kind          = htrl_pkg::KindScreen;
              res.address       = pend_addr_q;
              res.screen_number = screen_cnt_q;
              res.width         = pend_width_q;
              res.height        = pend_height_q;
              res.points        = pend_points_q;
              res.lines         = word_acc_q;
              res_valid         = 1'b1;
              pend_addr_d       = '0;
              pend_width_d      = '0;
              pend_height_d     = '0;
              pend_points_d     = '0;
              screen_cnt_d      = screen_cnt_q + 8'd1;
              step_d            = htrl_pkg::StepNone;
              word_mode_d       = 1'b0;
            end
            default: begin
            end
          endcase
        end
        word_acc_d = '0;
      end
    end else if (c == htrl_pkg::CharBlockData) begin
      step_d      = htrl_pkg::StepDataAddr;
      word_mode_d = 1'b1;
    end else if (c == htrl_pkg::CharBlockScreen) begin
      step_d      = htrl_pkg::StepScrAddr;
      word_mode_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= htrl_pkg::StepNone;
      word_mode_q   <= 1'b1;
      have_digits_q <= 1'b0;
      byte_acc_q    <= '0;
      word_acc_q    <= '0;
      cur_addr_q    <= '0;
      screen_cnt_q  <= '0;
      pend_addr_q   <= '0;
      pend_width_q  <= '0;
      pend_height_q <= '0;
      pend_points_q <= '0;
    end else if (accept) begin
      step_q        <= step_d;
      word_mode_q   <= word_mode_d;
      have_digits_q <= have_digits_d;
      byte_acc_q    <= byte_acc_d;
      word_acc_q    <= word_acc_d;
      cur_addr_q    <= cur_addr_d;
      screen_cnt_q  <= screen_cnt_d;
      pend_addr_q   <= pend_addr_d;
      pend_width_q  <= pend_width_d;
      pend_height_q <= pend_height_d;
      pend_points_q <= pend_points_d;
    end
  end

  // output register with one skid entry
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign record_kind_o    = out_q.kind;
  assign record_address_o = out_q.address;
  assign data_value_o     = out_q.data;
  assign screen_number_o  = out_q.screen_number;
  assign screen_width_o   = out_q.width;
  assign screen_height_o  = out_q.height;
  assign points_address_o = out_q.points;
  assign lines_address_o  = out_q.lines;

  `HTRL_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `HTRL_ASSERT_IMPL(a_byte_steps, clk_i, rst_ni,
                    step_q == htrl_pkg::StepDataByte || step_q == htrl_pkg::StepScrWidth ||
                    step_q == htrl_pkg::StepScrHeight, !word_mode_q)
  `HTRL_ASSERT_IMPL(a_word_steps, clk_i, rst_ni,
                    step_q == htrl_pkg::StepDataAddr || step_q == htrl_pkg::StepScrAddr ||
                    step_q == htrl_pkg::StepScrPoints || step_q == htrl_pkg::StepScrLines,
                    word_mode_q)
  `HTRL_ASSERT_NEXT(a_screen_count, clk_i, rst_ni,
                    accept && res_valid && res.kind == htrl_pkg::KindScreen,
                    screen_cnt_q == $past(screen_cnt_q) + 8'd1)

endmodule

`default_nettype wire
